// ===== src/kwsc_pkg.sv =====
// Shared types, constants and helpers for the keyword substitution cipher.
package kwsc_pkg;

    localparam int LETTERS = 26;
    localparam int LETTER_W = $clog2(LETTERS);
    localparam logic [7:0] LOWER_A = 8'd97;
    localparam logic [7:0] LOWER_Z = 8'd122;
    localparam logic [7:0] UPPER_A = 8'd65;

    typedef logic [LETTER_W-1:0] letter_t;

    typedef enum logic [1:0] {
        MODE_CLEAR = 2'd0,
        MODE_KEY   = 2'd1,
        MODE_TEXT  = 2'd2
    } mode_t;

    // Update request from the front stage to the key store.
    typedef struct packed {
        logic    clear;
        logic    add;
        letter_t idx;
    } key_op_t;

    // Key state seen by the cipher logic.
    // below[k] counts the key letters whose alphabet index is under k.
    typedef struct packed {
        logic [LETTERS-1:0]  used;
        letter_t             count;
        letter_t [LETTERS-1:0] letters;
        letter_t [LETTERS-1:0] below;
    } key_state_t;

    function automatic logic is_lower(input logic [7:0] b);
        return (b >= LOWER_A) && (b <= LOWER_Z);
    endfunction

    function automatic letter_t letter_of(input logic [7:0] b);
        logic [7:0] d;
        d = b - LOWER_A;
        return d[LETTER_W-1:0];
    endfunction

endpackage

// ===== src/kwsc_if.sv =====
// Valid/ready channel interfaces for input items and cipher results.
interface kwsc_in_if;
    import kwsc_pkg::*;
    logic   valid;
    logic   ready;
    mode_t  mode;
    logic [7:0] in_byte;

    modport source (output valid, output mode, output in_byte, input ready);
    modport sink   (input valid, input mode, input in_byte, output ready);
endinterface

interface kwsc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;

    modport source (output valid, output out_byte, input ready);
    modport sink   (input valid, input out_byte, output ready);
endinterface

// ===== src/kwsc_key_store.sv =====
// Key store: keyword letters, used-letter mask, count and per-letter rank table.
module kwsc_key_store (
    input  logic                 clk,
    input  logic                 rst_n,
    input  kwsc_pkg::key_op_t    op,
    output kwsc_pkg::key_state_t st
);
    import kwsc_pkg::*;

    logic [LETTERS-1:0]    used_reg, used_next;
    letter_t               count_reg, count_next;
    letter_t [LETTERS-1:0] letters_reg;
    letter_t [LETTERS-1:0] below_reg, below_next;
    logic                  take;

    assign take = op.add && !used_reg[op.idx] && (count_reg < letter_t'(LETTERS));

    always_comb
    begin
        used_next  = used_reg;
        count_next = count_reg;
        below_next = below_reg;
        if (op.clear)
        begin
            used_next  = '0;
            count_next = '0;
            below_next = '0;
        end
        else if (take)
        begin
            used_next[op.idx] = 1'b1;
            count_next        = count_reg + letter_t'(1);
            for (int k = 0; k < LETTERS; k++)
            begin
                if (letter_t'(k) > op.idx)
                begin
                    below_next[k] = below_reg[k] + letter_t'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg  <= '0;
            count_reg <= '0;
            below_reg <= '0;
        end
        else
        begin
            used_reg  <= used_next;
            count_reg <= count_next;
            below_reg <= below_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!op.clear && take)
        begin
            letters_reg[count_reg] <= op.idx;
        end
    end

    assign st.used    = used_reg;
    assign st.count   = count_reg;
    assign st.letters = letters_reg;
    assign st.below   = below_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= letter_t'(LETTERS))
        else $error("key count beyond alphabet");

    a_count_mask: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(used_reg) == int'(count_reg))
        else $error("key count disagrees with used mask");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        op.clear |=> (used_reg == '0) && (count_reg == '0))
        else $error("clear did not empty the key");

endmodule

// ===== src/kwsc_encrypt.sv =====
// Substitution lookup: maps a plaintext byte to its cipher byte.
module kwsc_encrypt (
    input  kwsc_pkg::key_state_t st,
    input  logic [7:0]           in_byte,
    output logic [7:0]           out_byte
);
    import kwsc_pkg::*;

    letter_t i;
    letter_t n;
    letter_t sub;
    letter_t fill;

    assign i = letter_of(in_byte);
    assign n = i - st.count;

    always_comb
    begin
        fill = letter_t'(LETTERS - 1);
        for (int k = 0; k < LETTERS; k++)
        begin
            if (!st.used[k] && (letter_t'(k) - st.below[k] == n))
            begin
                fill = letter_t'(k);
            end
        end
    end

    assign sub = (i < st.count) ? st.letters[i] : fill;

    assign out_byte = is_lower(in_byte) ? (UPPER_A + {3'b000, sub}) : in_byte;

endmodule

// ===== src/keyword_substitution_cipher.sv =====
// Top level: input register, key store, substitution lookup and result register.
// Takes one beat per cycle: mode 0 clears the key, mode 1 adds a keyword letter
// (non-lowercase or repeated letters are dropped), mode 2 encrypts a byte and
// yields exactly one result beat, mode 3 is dropped. A text beat is held in the
// input register, then the result register; throughput is one beat per cycle,
// limited only by result back-pressure, as key update and lookup share one stage.
module keyword_substitution_cipher (
    input  logic              clk,
    input  logic              rst_n,
    kwsc_in_if.sink           item,
    kwsc_out_if.source        result
);
    import kwsc_pkg::*;

    logic       s1_valid_reg, s1_valid_next;
    mode_t      s1_mode_reg;
    logic [7:0] s1_byte_reg;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg;
    logic       accept;
    logic       text;
    logic       s1_go;
    logic       load;
    logic [7:0] cipher;
    key_op_t    op;
    key_state_t st;

    assign text   = s1_valid_reg && (s1_mode_reg == MODE_TEXT);
    assign s1_go  = s1_valid_reg && (!text || !out_valid_reg || result.ready);
    assign load   = s1_go && text;
    assign accept = item.valid && item.ready;
    assign item.ready = !s1_valid_reg || s1_go;

    always_comb
    begin
        op.clear = 1'b0;
        op.add   = 1'b0;
        op.idx   = letter_of(s1_byte_reg);
        case (s1_mode_reg)
            MODE_CLEAR: op.clear = s1_go;
            MODE_KEY:   op.add   = s1_go && is_lower(s1_byte_reg);
            default:    ;
        endcase
    end

    kwsc_key_store u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (op),
        .st    (st)
    );

    kwsc_encrypt u_encrypt (
        .st       (st),
        .in_byte  (s1_byte_reg),
        .out_byte (cipher)
    );

    assign s1_valid_next  = accept || (s1_valid_reg && !s1_go);
    assign out_valid_next = load || (out_valid_reg && !result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_mode_reg <= item.mode;
            s1_byte_reg <= item.in_byte;
        end
        if (load)
        begin
            out_byte_reg <= cipher;
        end
    end

    assign result.valid    = out_valid_reg;
    assign result.out_byte = out_byte_reg;

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> out_valid_reg)
        else $error("text beat did not reach the result register");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> item.ready)
        else $error("empty front stage refused a beat");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (!out_valid_reg || result.ready))
        else $error("pending result overwritten");

endmodule
